// ===== sv/gfs_pkg.sv =====
// gfs_pkg: shared types and constants of the gradient fill shader
// no dependencies; imported by the shader top level

package gfs_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE        = 3'd0,
        REG_RECT_ORIGIN = 3'd1,
        REG_RECT_SIZE   = 3'd2,
        REG_RADIAL_GEOM = 3'd3,
        REG_COLOR_A     = 3'd4,
        REG_COLOR_B     = 3'd5,
        REG_COLOR_C     = 3'd6,
        REG_COLOR_D     = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        MODE_VERT   = 3'd0,
        MODE_HORZ   = 3'd1,
        MODE_DIAG   = 3'd2,
        MODE_BILIN  = 3'd3,
        MODE_RADIAL = 3'd4
    } mode_t;

    localparam int DIVA_W      = 24;   // |q - p| << 16
    localparam int DIVB_W      = 26;   // |vr - vl| and dist << 8
    localparam int DEN_W       = 16;
    localparam int SQRT_STAGES = 16;
    localparam int SQ_ALIGN    = DIVA_W - 1 - SQRT_STAGES;
    localparam int PIPE_DEPTH  = 1 + DIVA_W + 2 + DIVB_W + 2;
    localparam logic [8:0] T_MAX = 9'd256;

    // per-item data riding alongside the step dividers
    typedef struct packed {
        logic        in_rect;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] off;
        logic [2:0]  sgn_a;
        logic [2:0]  sgn_b;
    } side_t;

    // per-item data riding alongside the row divider
    typedef struct packed {
        logic             in_rect;
        logic [15:0]      dx;
        logic [2:0]       dsgn;
        logic [2:0][23:0] vl;
    } mid_t;

endpackage

// ===== sv/gfs_div.sv =====
// gfs_div: pipelined unsigned restoring divider, one quotient bit per stage
// self-contained; advances when en is high

module gfs_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] nq_next;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign nq_in  = nq_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        assign trial    = {rem_in, nq_in[NUM_W-1]};
        assign diff     = trial - {1'b0, den_in};
        assign ge       = (trial >= {1'b0, den_in});
        assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign nq_next  = {nq_in[NUM_W-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                nq_reg[s]  <= nq_next;
                den_reg[s] <= den_in;
            end
        end
    end

    assign quo = nq_reg[NUM_W-1];

endmodule

// ===== sv/gfs_sqrt.sv =====
// gfs_sqrt: pipelined integer square root of a 32-bit value, one result bit per stage
// self-contained; advances when en is high

module gfs_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] n,
    output logic [15:0] root
);

    localparam int STAGES = 16;

    logic [31:0] n_reg [STAGES];
    logic [31:0] r_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic [31:0] BIT = 32'd1 << (30 - 2 * i);
        logic [31:0] n_in;
        logic [31:0] r_in;
        logic [32:0] sum;
        logic        ge;
        logic [31:0] n_next;
        logic [31:0] r_next;

        if (i == 0)
        begin : g_first
            assign n_in = n;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign n_in = n_reg[i-1];
            assign r_in = r_reg[i-1];
        end

        assign sum    = {1'b0, r_in} + {1'b0, BIT};
        assign ge     = ({1'b0, n_in} >= sum);
        assign n_next = ge ? (n_in - sum[31:0]) : n_in;
        assign r_next = ge ? ((r_in >> 1) + BIT) : (r_in >> 1);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i] <= n_next;
                r_reg[i] <= r_next;
            end
        end
    end

    assign root = r_reg[STAGES-1][15:0];

endmodule

// ===== sv/gfs_dly.sv =====
// gfs_dly: enabled shift line that keeps side data in step with a pipelined unit
// self-contained; advances when en is high

module gfs_dly #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sr_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign q = sr_reg[N-1];

endmodule

// ===== sv/gradient_fill_shader_top.sv =====
// gradient_fill_shader_top: pixel coordinate in, gradient colour and inside flag out
// one item per cycle sustained while the result is not stalled
// most of the depth: the 24-stage step dividers and the 26-stage row/radius dividers
// the whole pipeline holds while a result is stalled
// reset clears valid bits and loads default configuration; no clearing pass
// uses gfs_pkg, gfs_div, gfs_sqrt, gfs_dly

module gradient_fill_shader_top
    import gfs_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  inside_res,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [47:0]           cfg_data
);

    // configuration
    logic [2:0]  mode_reg;
    logic [31:0] origin_reg;
    logic [31:0] size_reg;
    logic [47:0] geom_reg;
    logic [23:0] color_a_reg;
    logic [23:0] color_b_reg;
    logic [23:0] color_c_reg;
    logic [23:0] color_d_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            origin_reg  <= '0;
            size_reg    <= 32'h0001_0001;
            geom_reg    <= 48'd1;
            color_a_reg <= '0;
            color_b_reg <= '0;
            color_c_reg <= '0;
            color_d_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MODE:        mode_reg    <= cfg_data[2:0];
                REG_RECT_ORIGIN: origin_reg  <= cfg_data[31:0];
                REG_RECT_SIZE:   size_reg    <= cfg_data[31:0];
                REG_RADIAL_GEOM: geom_reg    <= cfg_data;
                REG_COLOR_A:     color_a_reg <= cfg_data[23:0];
                REG_COLOR_B:     color_b_reg <= cfg_data[23:0];
                REG_COLOR_C:     color_c_reg <= cfg_data[23:0];
                REG_COLOR_D:     color_d_reg <= cfg_data[23:0];
                default:         ;
            endcase
        end
    end

    // pipeline control
    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;

    assign en        = !(vld_reg[PIPE_DEPTH-1] && res_stall);
    assign pix_stall = !en;
    assign res_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], pix_valid};
        end
    end

    // derived geometry
    logic signed [17:0] ox;
    logic signed [17:0] oy;
    logic signed [17:0] w;
    logic signed [17:0] h;
    logic signed [17:0] cx;
    logic signed [17:0] cy;
    logic signed [15:0] rad_raw;
    logic [15:0]        divx;
    logic [15:0]        divy;
    logic [15:0]        tot;
    logic [15:0]        rad;
    logic signed [17:0] wh_sum;

    assign ox      = 18'(signed'(origin_reg[31:16]));
    assign oy      = 18'(signed'(origin_reg[15:0]));
    assign w       = 18'(signed'(size_reg[31:16]));
    assign h       = 18'(signed'(size_reg[15:0]));
    assign cx      = 18'(signed'(geom_reg[47:32]));
    assign cy      = 18'(signed'(geom_reg[31:16]));
    assign rad_raw = signed'(geom_reg[15:0]);
    assign wh_sum  = w + h;
    assign divx    = (w > 18'sd1) ? 16'(w - 18'sd1) : 16'd1;
    assign divy    = (h > 18'sd1) ? 16'(h - 18'sd1) : 16'd1;
    assign tot     = (wh_sum > 18'sd2) ? 16'(wh_sum - 18'sd2) : 16'd1;
    assign rad     = (rad_raw <= 16'sd0) ? 16'd1 : 16'(rad_raw);

    // stage 1: coordinate capture
    logic [COORD_BITS-1:0] px1_reg;
    logic [COORD_BITS-1:0] py1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px1_reg <= pixel_x;
            py1_reg <= pixel_y;
        end
    end

    logic signed [17:0] px18;
    logic signed [17:0] py18;
    logic signed [17:0] dx18;
    logic signed [17:0] dy18;
    logic               inside1;
    logic [15:0]        off1;
    logic [15:0]        den_a;
    side_t              side1;
    side_t              side25;

    assign px18    = signed'({{(18 - COORD_BITS){1'b0}}, px1_reg});
    assign py18    = signed'({{(18 - COORD_BITS){1'b0}}, py1_reg});
    assign dx18    = px18 - ox;
    assign dy18    = py18 - oy;
    assign inside1 = (w > 18'sd0) && (h > 18'sd0) && (dx18 >= 18'sd0) && (dx18 < w)
                     && (dy18 >= 18'sd0) && (dy18 < h);

    always_comb
    begin
        case (mode_t'(mode_reg))
            MODE_HORZ:
            begin
                off1  = dx18[15:0];
                den_a = divx;
            end
            MODE_DIAG:
            begin
                off1  = dx18[15:0] + dy18[15:0];
                den_a = tot;
            end
            default:
            begin
                off1  = dy18[15:0];
                den_a = divy;
            end
        endcase
    end

    logic [DIVA_W-1:0] qa [3];
    logic [DIVA_W-1:0] qb [3];
    logic [2:0]        sgn_a1;
    logic [2:0]        sgn_b1;

    for (genvar k = 0; k < 3; k++)
    begin : g_div_a
        logic [7:0]        ca;
        logic [7:0]        cb;
        logic [7:0]        cc;
        logic [7:0]        cd;
        logic signed [8:0] na;
        logic signed [8:0] nb;
        logic [8:0]        ma;
        logic [8:0]        mb;

        assign ca = color_a_reg[8*(2-k) +: 8];
        assign cb = color_b_reg[8*(2-k) +: 8];
        assign cc = color_c_reg[8*(2-k) +: 8];
        assign cd = color_d_reg[8*(2-k) +: 8];
        assign na = (mode_t'(mode_reg) == MODE_BILIN) ? signed'({1'b0, cc} - {1'b0, ca})
                                                      : signed'({1'b0, cb} - {1'b0, ca});
        assign nb = signed'({1'b0, cd} - {1'b0, cb});
        assign ma = na[8] ? 9'(-na) : 9'(na);
        assign mb = nb[8] ? 9'(-nb) : 9'(nb);
        assign sgn_a1[k] = na[8];
        assign sgn_b1[k] = nb[8];

        gfs_div #(.NUM_W(DIVA_W), .DEN_W(DEN_W)) u_div_a (
            .clk (clk),
            .en  (en),
            .num ({ma[7:0], 16'h0000}),
            .den (den_a),
            .quo (qa[k])
        );

        gfs_div #(.NUM_W(DIVA_W), .DEN_W(DEN_W)) u_div_b (
            .clk (clk),
            .en  (en),
            .num ({mb[7:0], 16'h0000}),
            .den (divy),
            .quo (qb[k])
        );
    end

    assign side1.in_rect = inside1;
    assign side1.dx      = dx18[15:0];
    assign side1.dy      = dy18[15:0];
    assign side1.off     = off1;
    assign side1.sgn_a   = sgn_a1;
    assign side1.sgn_b   = sgn_b1;

    gfs_dly #(.W($bits(side_t)), .N(DIVA_W)) u_dly_side (
        .clk (clk),
        .en  (en),
        .d   (side1),
        .q   (side25)
    );

    // radial distance: squares, then root
    logic signed [17:0] ex;
    logic signed [17:0] ey;
    logic signed [35:0] exsq;
    logic signed [35:0] eysq;
    logic [33:0]        sqx_reg;
    logic [33:0]        sqy_reg;
    logic [34:0]        d2;
    logic [31:0]        d2_sat;
    logic [15:0]        dist18;
    logic [15:0]        dist25;

    assign ex   = px18 - cx;
    assign ey   = py18 - cy;
    assign exsq = ex * ex;
    assign eysq = ey * ey;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= exsq[33:0];
            sqy_reg <= eysq[33:0];
        end
    end

    assign d2     = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign d2_sat = (|d2[34:32]) ? 32'hFFFF_FFFF : d2[31:0];

    gfs_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .n    (d2_sat),
        .root (dist18)
    );

    gfs_dly #(.W(16), .N(SQ_ALIGN)) u_dly_dist (
        .clk (clk),
        .en  (en),
        .d   (dist18),
        .q   (dist25)
    );

    // stage M1: step products
    logic signed [27:0] m1_reg [3];
    logic signed [27:0] mr_reg [3];
    side_t              side26_reg;
    logic [15:0]        dist26_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_m1
        logic signed [24:0] step_a;
        logic signed [24:0] step_b;
        logic signed [41:0] prod_a;
        logic signed [41:0] prod_b;

        assign step_a = side25.sgn_a[k] ? -signed'({1'b0, qa[k]}) : signed'({1'b0, qa[k]});
        assign step_b = side25.sgn_b[k] ? -signed'({1'b0, qb[k]}) : signed'({1'b0, qb[k]});
        assign prod_a = step_a * signed'({1'b0, side25.off});
        assign prod_b = step_b * signed'({1'b0, side25.dy});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m1_reg[k] <= prod_a[27:0];
                mr_reg[k] <= prod_b[27:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side26_reg <= side25;
            dist26_reg <= dist25;
        end
    end

    // stage M2: edge values and row difference
    logic [DIVB_W-1:0] dmag_reg [3];
    mid_t              mid27_reg;
    mid_t              mid_next;
    logic [15:0]       dist27_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_m2
        logic signed [27:0] vl;
        logic signed [27:0] vr;
        logic signed [27:0] diff;
        logic [27:0]        mag;

        assign vl   = signed'({4'h0, color_a_reg[8*(2-k) +: 8], 16'h0000}) + m1_reg[k];
        assign vr   = signed'({4'h0, color_b_reg[8*(2-k) +: 8], 16'h0000}) + mr_reg[k];
        assign diff = vr - vl;
        assign mag  = diff[27] ? 28'(-diff) : 28'(diff);
        assign mid_next.vl[k]   = vl[23:0];
        assign mid_next.dsgn[k] = diff[27];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dmag_reg[k] <= mag[DIVB_W-1:0];
            end
        end
    end

    assign mid_next.in_rect = side26_reg.in_rect;
    assign mid_next.dx      = side26_reg.dx;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid27_reg  <= mid_next;
            dist27_reg <= dist26_reg;
        end
    end

    // row and radius dividers
    logic [DIVB_W-1:0] qx [3];
    logic [DIVB_W-1:0] qt;
    mid_t              mid53;

    for (genvar k = 0; k < 3; k++)
    begin : g_div_b
        gfs_div #(.NUM_W(DIVB_W), .DEN_W(DEN_W)) u_div_x (
            .clk (clk),
            .en  (en),
            .num (dmag_reg[k]),
            .den (divx),
            .quo (qx[k])
        );
    end

    gfs_div #(.NUM_W(DIVB_W), .DEN_W(DEN_W)) u_div_t (
        .clk (clk),
        .en  (en),
        .num ({{(DIVB_W - 24){1'b0}}, dist27_reg, 8'h00}),
        .den (rad),
        .quo (qt)
    );

    gfs_dly #(.W($bits(mid_t)), .N(DIVB_W)) u_dly_mid (
        .clk (clk),
        .en  (en),
        .d   (mid27_reg),
        .q   (mid53)
    );

    // stage E1: row interpolation, radial fraction
    logic [7:0] lin_reg [3];
    logic [7:0] bil_reg [3];
    logic [8:0] t_reg;
    logic       inside54_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_e1
        logic [23:0] sx;
        logic [39:0] p;
        logic [23:0] v;

        assign sx = mid53.dsgn[k] ? 24'(-qx[k]) : qx[k][23:0];
        assign p  = sx * mid53.dx;
        assign v  = mid53.vl[k] + p[23:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lin_reg[k] <= mid53.vl[k][23:16];
                bil_reg[k] <= v[23:16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg        <= (qt > DIVB_W'(T_MAX)) ? T_MAX : qt[8:0];
            inside54_reg <= mid53.in_rect;
        end
    end

    // stage E2: radial blend, mode select, result register
    logic [7:0] col_next [3];
    logic [7:0] col_reg  [3];
    logic       inside_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_e2
        logic [7:0]         ca;
        logic signed [8:0]  bma;
        logic signed [18:0] prod;
        logic signed [18:0] sh;
        logic [7:0]         radc;

        assign ca   = color_a_reg[8*(2-k) +: 8];
        assign bma  = signed'({1'b0, color_b_reg[8*(2-k) +: 8]} - {1'b0, ca});
        assign prod = bma * signed'({1'b0, t_reg});
        assign sh   = prod >>> 8;
        assign radc = ca + sh[7:0];

        always_comb
        begin
            case (mode_t'(mode_reg))
                MODE_VERT,
                MODE_HORZ,
                MODE_DIAG:   col_next[k] = lin_reg[k];
                MODE_BILIN:  col_next[k] = bil_reg[k];
                MODE_RADIAL: col_next[k] = radc;
                default:     col_next[k] = 8'h00;
            endcase
            if (!inside54_reg)
            begin
                col_next[k] = 8'h00;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                col_reg[k] <= col_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_reg <= inside54_reg;
        end
    end

    assign inside_res = inside_reg;
    assign red        = col_reg[0];
    assign green      = col_reg[1];
    assign blue       = col_reg[2];

    // checks
    a_outside_black: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !inside_res) |-> (red == 8'h00 && green == 8'h00 && blue == 8'h00))
        else $error("pixel outside rectangle carries a colour");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while result stalled");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_stall && !res_stall) |=> !$past(res_valid && res_stall) || pix_stall == 1'b0
        || res_valid)
        else $error("input held without a stalled result");

endmodule
